// File: design/genotype_ancestry_classifier_core_defines.svh
// assertion macros shared by the classifier core
`ifndef GENOTYPE_ANCESTRY_CLASSIFIER_CORE_DEFINES_SVH
`define GENOTYPE_ANCESTRY_CLASSIFIER_CORE_DEFINES_SVH
`ifndef SYNTH
`define GAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define GAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next cycle check failed");
`else
`define GAC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GAC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/gac_pkg.sv
// constants, codes and payload types of the ancestry classifier
`default_nettype none
package gac_pkg;

    localparam int POPULATIONS = 5;
    localparam int MAX_MARKERS = 255;
    localparam int SLOTS       = 8;
    localparam int POP_W       = 3;

    localparam logic [POP_W-1:0] LAST_POP = POP_W'(POPULATIONS - 1);

    localparam int LN_W     = 21;
    localparam int LL_W     = 32;
    localparam int SPREAD_W = 24;
    localparam int CNT_W    = 8;

    localparam logic [15:0] FREQ_LO = 16'd66;
    localparam logic [15:0] FREQ_HI = 16'd65470;
    localparam int          LN2_Q16 = 45426;
    localparam int          K_LIMIT = 31;
    localparam logic [31:0] D_LIMIT = 32'(K_LIMIT * LN2_Q16);
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [3:0]  TERMS   = 4'd12;

    localparam logic [CNT_W-1:0]    HIGH_COUNT  = 8'd40;
    localparam logic [SPREAD_W-1:0] HIGH_SPREAD = 24'd983040;
    localparam logic [CNT_W-1:0]    MOD_COUNT   = 8'd20;
    localparam logic [SPREAD_W-1:0] MOD_SPREAD  = 24'd524288;

    localparam logic [15:0] UNIFORM_SHARE = 16'((65536 + POPULATIONS / 2) / POPULATIONS);

    localparam int DIV_N_W   = 47;
    localparam int DIV_D_W   = 34;
    localparam int DIV_CNT_W = 6;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [1:0] CONF_NONE = 2'd0;
    localparam logic [1:0] CONF_LOW  = 2'd1;
    localparam logic [1:0] CONF_MOD  = 2'd2;
    localparam logic [1:0] CONF_HIGH = 2'd3;

    localparam logic signed [3:0] TOP_NONE = -4'sd1;

    typedef struct packed {
        logic        operation;
        logic [1:0]  copies;
        logic [15:0] freq_0;
        logic [15:0] freq_1;
        logic [15:0] freq_2;
        logic [15:0] freq_3;
        logic [15:0] freq_4;
        logic [15:0] freq_5;
        logic [15:0] freq_6;
        logic [15:0] freq_7;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        share_0;
        logic [15:0]        share_1;
        logic [15:0]        share_2;
        logic [15:0]        share_3;
        logic [15:0]        share_4;
        logic [15:0]        share_5;
        logic [15:0]        share_6;
        logic [15:0]        share_7;
        logic signed [3:0]  best_pop;
        logic [1:0]         confidence;
        logic [7:0]         marker_total;
    } t_out_item;

    // decoded command held in the queue between front and back
    typedef struct packed {
        logic                   finish;
        logic [1:0]             count;
        logic [SLOTS-1:0][15:0] freq;
        logic [15:0]            spread;
    } t_cmd;

endpackage
`default_nettype wire

// File: design/gac_front.sv
// front end: accepts items, decodes them and queues the commands
`default_nettype none
module gac_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire gac_pkg::t_in_item i_item,
    output logic                   o_cmd_valid,
    output gac_pkg::t_cmd          o_cmd,
    input  wire logic              i_cmd_pop
);

    gac_pkg::t_cmd                 r_q [gac_pkg::Q_DEPTH];
    logic [gac_pkg::Q_PTR_W-1:0]   r_wp;
    logic [gac_pkg::Q_PTR_W-1:0]   r_rp;
    logic [gac_pkg::Q_CNT_W-1:0]   r_cnt;
    logic [gac_pkg::Q_CNT_W-1:0]   n_cnt;
    logic [gac_pkg::SLOTS-1:0][15:0] w_freq;
    logic [15:0]                   w_lo;
    logic [15:0]                   w_hi;
    gac_pkg::t_cmd                 w_cmd;
    logic                          w_push;
    logic                          w_pop;

    assign w_freq = {i_item.freq_7, i_item.freq_6, i_item.freq_5, i_item.freq_4,
                     i_item.freq_3, i_item.freq_2, i_item.freq_1, i_item.freq_0};

    // spread over the populations in use
    always_comb begin
        w_lo = w_freq[0];
        w_hi = w_freq[0];
        for (int p = 1; p < gac_pkg::POPULATIONS; p++) begin
            if (w_freq[p] < w_lo) w_lo = w_freq[p];
            if (w_freq[p] > w_hi) w_hi = w_freq[p];
        end
    end

    always_comb begin
        w_cmd.finish = (i_item.operation == gac_pkg::OP_FINISH);
        w_cmd.count  = (i_item.copies == 2'd3) ? 2'd2 : i_item.copies;
        w_cmd.freq   = w_freq;
        w_cmd.spread = w_hi - w_lo;
    end

    assign o_stall     = (r_cnt == gac_pkg::Q_CNT_W'(gac_pkg::Q_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && !o_stall;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) n_cnt = r_cnt + 1'b1;
        if (!w_push && w_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_q[r_wp] <= w_cmd;
                r_wp      <= r_wp + 1'b1;
            end
            if (w_pop) r_rp <= r_rp + 1'b1;
        end
    end

endmodule
`default_nettype wire

// File: design/gac_log.sv
// iterative -ln of a q0.16 value, one squaring step per cycle
`default_nettype none
module gac_log (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [15:0]              i_x,
    output logic                          o_done,
    output logic [gac_pkg::LN_W-1:0]      o_value
);

    typedef enum logic [1:0] {L_IDLE, L_SQ, L_MAG, L_MUL} t_lstate;

    t_lstate                 r_state;
    logic [30:0]             r_m;
    logic [3:0]              r_e;
    logic [15:0]             r_frac;
    logic [3:0]              r_cnt;
    logic [gac_pkg::LN_W-1:0] r_mag;
    logic [3:0]              w_e;
    logic [30:0]             w_norm;
    logic [61:0]             w_sq;
    logic [31:0]             w_t;
    logic [30:0]             n_m;
    logic [36:0]             w_prod;

    // position of the leading one
    always_comb begin
        w_e = '0;
        for (int b = 0; b < 16; b++) begin
            if (i_x[b]) w_e = 4'(b);
        end
    end

    assign w_norm = {15'b0, i_x} << (5'd30 - {1'b0, w_e});
    assign w_sq   = {31'b0, r_m} * {31'b0, r_m};
    assign w_t    = w_sq[61:30];
    assign n_m    = w_t[31] ? w_t[31:1] : w_t[30:0];
    assign w_prod = {16'b0, r_mag} * 37'(gac_pkg::LN2_Q16) + 37'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_m     <= w_norm;
                        r_e     <= w_e;
                        r_frac  <= '0;
                        r_cnt   <= '0;
                        r_state <= L_SQ;
                    end
                end
                L_SQ: begin
                    r_m    <= n_m;
                    r_frac <= {r_frac[14:0], w_t[31]};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) r_state <= L_MAG;
                end
                L_MAG: begin
                    r_mag   <= {5'd16 - {1'b0, r_e}, 16'b0} - {5'b0, r_frac};
                    r_state <= L_MUL;
                end
                L_MUL: begin
                    o_value <= w_prod[36:16];
                    o_done  <= 1'b1;
                    r_state <= L_IDLE;
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: design/gac_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module gac_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [gac_pkg::DIV_N_W-1:0] i_num,
    input  wire logic [gac_pkg::DIV_D_W-1:0] i_den,
    output logic                             o_done,
    output logic [gac_pkg::DIV_N_W-1:0]      o_quo
);

    logic                            r_busy;
    logic [gac_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [gac_pkg::DIV_N_W-1:0]     r_num;
    logic [gac_pkg::DIV_D_W-1:0]     r_den;
    logic [gac_pkg::DIV_D_W-1:0]     r_rem;
    logic [gac_pkg::DIV_N_W-1:0]     r_quo;
    logic [gac_pkg::DIV_D_W:0]       w_trial;
    logic                            w_ge;
    logic [gac_pkg::DIV_D_W:0]       w_diff;

    assign w_trial = {r_rem, r_num[gac_pkg::DIV_N_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_num  <= i_num;
                    r_den  <= i_den;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end
            end else begin
                r_rem <= w_ge ? w_diff[gac_pkg::DIV_D_W-1:0] : w_trial[gac_pkg::DIV_D_W-1:0];
                r_num <= {r_num[gac_pkg::DIV_N_W-2:0], 1'b0};
                r_quo <= {r_quo[gac_pkg::DIV_N_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == gac_pkg::DIV_CNT_W'(gac_pkg::DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: design/gac_back.sv
// back end: likelihood accumulation and the finishing softmax sequence
`default_nettype none
module gac_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    input  wire gac_pkg::t_cmd      i_cmd,
    output logic                    o_cmd_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output gac_pkg::t_out_item      o_item
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_LOG_A, S_LOG_B, S_ARGMAX, S_WINIT, S_REDUCE,
        S_TMUL, S_TDIV, S_WSTORE, S_SHARE_START, S_SHARE, S_OUT
    } t_state;

    t_state                            r_state;
    gac_pkg::t_cmd                     r_cmd;
    logic [gac_pkg::POP_W-1:0]         r_p;
    logic signed [gac_pkg::LL_W-1:0]   r_ll [gac_pkg::SLOTS];
    logic [gac_pkg::SPREAD_W-1:0]      r_spread_sum;
    logic [gac_pkg::CNT_W-1:0]         r_count;
    logic [gac_pkg::LN_W-1:0]          r_lna;
    logic signed [gac_pkg::LL_W-1:0]   r_max;
    logic [gac_pkg::POP_W-1:0]         r_top;
    logic [20:0]                       r_r;
    logic [4:0]                        r_k;
    logic [30:0]                       r_term;
    logic signed [32:0]                r_sum;
    logic [3:0]                        r_i;
    logic [30:0]                       r_w [gac_pkg::SLOTS];
    logic [33:0]                       r_total;
    logic [15:0]                       r_share [gac_pkg::SLOTS];
    logic                              r_log_start;
    logic [15:0]                       r_log_x;
    logic                              r_div_start;
    logic [gac_pkg::DIV_N_W-1:0]       r_div_num;
    logic [gac_pkg::DIV_D_W-1:0]       r_div_den;
    logic                              r_out_valid;
    gac_pkg::t_out_item                r_out;

    logic                              w_log_done;
    logic [gac_pkg::LN_W-1:0]          w_log_value;
    logic                              w_div_done;
    logic [gac_pkg::DIV_N_W-1:0]       w_div_quo;
    logic [15:0]                       w_c;
    logic [gac_pkg::LN_W:0]            w_delta;
    logic [31:0]                       w_d;
    logic [46:0]                       w_tprod;
    logic [30:0]                       w_wval;
    logic [30:0]                       w_term_new;
    logic [1:0]                        w_conf;

    function automatic logic [15:0] f_clamp(logic [15:0] x);
        if (x < gac_pkg::FREQ_LO) return gac_pkg::FREQ_LO;
        if (x > gac_pkg::FREQ_HI) return gac_pkg::FREQ_HI;
        return x;
    endfunction

    gac_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_log_start),
        .i_x     (r_log_x),
        .o_done  (w_log_done),
        .o_value (w_log_value)
    );

    gac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign w_c = f_clamp(r_cmd.freq[r_p]);

    always_comb begin
        case (r_cmd.count)
            2'd0:    w_delta = {w_log_value, 1'b0};
            2'd1:    w_delta = {1'b0, r_lna} + {1'b0, w_log_value};
            default: w_delta = {r_lna, 1'b0};
        endcase
    end

    assign w_d        = 32'(r_max - r_ll[r_p]);
    assign w_tprod    = {16'b0, r_term} * {31'b0, r_r[15:0]};
    assign w_wval     = r_sum[32] ? 31'd0 : (r_sum[30:0] >> r_k);
    assign w_term_new = w_div_quo[30:0];

    always_comb begin
        if (r_count == '0)
            w_conf = gac_pkg::CONF_NONE;
        else if (r_count >= gac_pkg::HIGH_COUNT && r_spread_sum >= gac_pkg::HIGH_SPREAD)
            w_conf = gac_pkg::CONF_HIGH;
        else if (r_count >= gac_pkg::MOD_COUNT && r_spread_sum >= gac_pkg::MOD_SPREAD)
            w_conf = gac_pkg::CONF_MOD;
        else
            w_conf = gac_pkg::CONF_LOW;
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign o_valid   = r_out_valid;
    assign o_item    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_log_start  <= 1'b0;
            r_div_start  <= 1'b0;
            r_spread_sum <= '0;
            r_count      <= '0;
            for (int p = 0; p < gac_pkg::SLOTS; p++) r_ll[p] <= '0;
        end else begin
            r_log_start <= 1'b0;
            r_div_start <= 1'b0;
            // the output state reloads the register itself
            if (r_out_valid && !i_stall && r_state != S_OUT) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_p     <= '0;
                        r_total <= '0;
                        if (i_cmd.finish) begin
                            for (int p = 0; p < gac_pkg::SLOTS; p++) begin
                                r_share[p] <= (r_count == '0 && p < gac_pkg::POPULATIONS) ?
                                              gac_pkg::UNIFORM_SHARE : 16'd0;
                            end
                            r_state <= (r_count == '0) ? S_OUT : S_ARGMAX;
                        end else if (r_count < gac_pkg::CNT_W'(gac_pkg::MAX_MARKERS)) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_log_start <= 1'b1;
                    r_log_x     <= w_c;
                    r_state     <= S_LOG_A;
                end
                S_LOG_A: begin
                    if (w_log_done) begin
                        r_lna       <= w_log_value;
                        r_log_start <= 1'b1;
                        r_log_x     <= 16'(17'h10000 - {1'b0, w_c});
                        r_state     <= S_LOG_B;
                    end
                end
                S_LOG_B: begin
                    if (w_log_done) begin
                        r_ll[r_p] <= r_ll[r_p] -
                            $signed({(gac_pkg::LL_W - gac_pkg::LN_W - 1)'(0), w_delta});
                        if (r_p == gac_pkg::LAST_POP) begin
                            r_spread_sum <= r_spread_sum + {8'b0, r_cmd.spread};
                            r_count      <= r_count + 1'b1;
                            r_state      <= S_IDLE;
                        end else begin
                            r_p     <= r_p + 1'b1;
                            r_state <= S_START;
                        end
                    end
                end
                S_ARGMAX: begin
                    if (r_p == '0 || r_ll[r_p] > r_max) begin
                        r_max <= r_ll[r_p];
                        r_top <= r_p;
                    end
                    if (r_p == gac_pkg::LAST_POP) begin
                        r_p     <= '0;
                        r_state <= S_WINIT;
                    end else begin
                        r_p <= r_p + 1'b1;
                    end
                end
                S_WINIT: begin
                    if (w_d >= gac_pkg::D_LIMIT) begin
                        r_w[r_p] <= '0;
                        if (r_p == gac_pkg::LAST_POP) begin
                            r_p     <= '0;
                            r_state <= S_SHARE_START;
                        end else begin
                            r_p <= r_p + 1'b1;
                        end
                    end else begin
                        r_r     <= w_d[20:0];
                        r_k     <= '0;
                        r_state <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    if (r_r >= 21'(gac_pkg::LN2_Q16)) begin
                        r_r <= r_r - 21'(gac_pkg::LN2_Q16);
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_term  <= gac_pkg::ONE_Q30;
                        r_sum   <= $signed({2'b0, gac_pkg::ONE_Q30});
                        r_i     <= 4'd1;
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    r_div_num   <= {16'b0, w_tprod[46:16]};
                    r_div_den   <= {30'b0, r_i};
                    r_div_start <= 1'b1;
                    r_state     <= S_TDIV;
                end
                S_TDIV: begin
                    if (w_div_done) begin
                        r_term <= w_term_new;
                        if (r_i[0]) r_sum <= r_sum - $signed({2'b0, w_term_new});
                        else        r_sum <= r_sum + $signed({2'b0, w_term_new});
                        if (r_i == gac_pkg::TERMS) begin
                            r_state <= S_WSTORE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_TMUL;
                        end
                    end
                end
                S_WSTORE: begin
                    r_w[r_p] <= w_wval;
                    r_total  <= r_total + {3'b0, w_wval};
                    if (r_p == gac_pkg::LAST_POP) begin
                        r_p     <= '0;
                        r_state <= S_SHARE_START;
                    end else begin
                        r_p     <= r_p + 1'b1;
                        r_state <= S_WINIT;
                    end
                end
                S_SHARE_START: begin
                    r_div_num   <= {r_w[r_p], 16'b0} + {14'b0, r_total[33:1]};
                    r_div_den   <= (r_total == '0) ? 34'd1 : r_total;
                    r_div_start <= 1'b1;
                    r_state     <= S_SHARE;
                end
                S_SHARE: begin
                    if (w_div_done) begin
                        r_share[r_p] <= (|w_div_quo[46:16]) ? 16'hFFFF : w_div_quo[15:0];
                        if (r_p == gac_pkg::LAST_POP) begin
                            r_state <= S_OUT;
                        end else begin
                            r_p     <= r_p + 1'b1;
                            r_state <= S_SHARE_START;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid         <= 1'b1;
                        r_out.share_0       <= r_share[0];
                        r_out.share_1       <= r_share[1];
                        r_out.share_2       <= r_share[2];
                        r_out.share_3       <= r_share[3];
                        r_out.share_4       <= r_share[4];
                        r_out.share_5       <= r_share[5];
                        r_out.share_6       <= r_share[6];
                        r_out.share_7       <= r_share[7];
                        r_out.best_pop      <= (r_count == '0) ? gac_pkg::TOP_NONE :
                                               $signed({1'b0, r_top});
                        r_out.confidence    <= w_conf;
                        r_out.marker_total  <= r_count;
                        r_spread_sum        <= '0;
                        r_count             <= '0;
                        for (int p = 0; p < gac_pkg::SLOTS; p++) r_ll[p] <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: design/genotype_ancestry_classifier_core.sv
// top level of the naive-bayes ancestry classifier core
// usage:
//  - input channel i_in_valid / o_in_stall carries i_in_data; a transfer happens on a
//    rising edge with valid high and stall low
//  - an add item (operation 0) folds one marker into the per-population log-likelihoods,
//    the spread sum and the marker count unless 255 are counted; it gives no result
//  - a finish item (operation 1) gives one result on o_out_valid / i_out_stall:
//    softmax shares, most likely population, confidence and marker count, then clears
//  - a two-entry command queue sits behind the input, so up to two items are taken while
//    the back end works or a result waits in the output register
//  - an add item holds the back end while, for each population, it runs two iterative
//    logarithms, each made of 16 squaring steps
//  - a finish with markers finds the top population, then per population takes k ln 2
//    reductions (at most 30) and twelve series terms, each term a serial division, or
//    none of these where the weight underflows, and then one share division each;
//    a finish with no markers goes straight to the output register
//  - synchronous active-low reset clears all accumulated state, the queue and the
//    output valid; no clearing pass is needed
//  - while the receiver stalls, the result holds in the output register and the back
//    end waits before emitting the next one
`default_nettype none
`include "genotype_ancestry_classifier_core_defines.svh"
module genotype_ancestry_classifier_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire gac_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output gac_pkg::t_out_item      o_out_data
);

    // command queue between front and back
    logic          w_cmd_valid;
    gac_pkg::t_cmd w_cmd;
    logic          w_cmd_pop;

    // front decodes items and computes the frequency spread
    gac_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_item      (i_in_data),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // back runs the log and softmax sequences and owns the output register
    gac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_item      (o_out_data)
    );

    // a full queue can never look empty to the back end
    `GAC_ASSERT_IMP(a_stall_has_cmd, i_clk, i_rst_n, o_in_stall, w_cmd_valid)
    // a transfer into an empty queue shows up there on the next cycle
    `GAC_ASSERT_NXT(a_push_visible, i_clk, i_rst_n, i_in_valid && !o_in_stall && !w_cmd_valid, w_cmd_valid)
    // an empty sample reports no population and no confidence
    `GAC_ASSERT_IMP(a_empty_result, i_clk, i_rst_n, o_out_valid && o_out_data.marker_total == 8'd0, o_out_data.best_pop == gac_pkg::TOP_NONE && o_out_data.confidence == gac_pkg::CONF_NONE)
    // with markers the winner is one of the populations in use
    `GAC_ASSERT_IMP(a_top_range, i_clk, i_rst_n, o_out_valid && o_out_data.marker_total != 8'd0, o_out_data.best_pop >= 0 && o_out_data.best_pop < gac_pkg::POPULATIONS)

endmodule
`default_nettype wire
